@@ hw/rtl/ssrch_pkg.sv @@
// ----------------------------------------------------------------------------
// Streaming substring search package
// Sizes, register indexes and shared types for the substring search block.
// ----------------------------------------------------------------------------
package ssrch_pkg;

  // Longest needle the window can hold (1 to 32).
  localparam int MAX_NEEDLE    = 32;
  // Width of the haystack position counter (8 to 64).
  localparam int POSITION_BITS = 32;

  // The needle registers always hold 32 bytes in four 64-bit words.
  localparam int NEEDLE_SLOTS  = 32;
  localparam int NEEDLE_WORDS  = 4;
  localparam int SLOT_W        = $clog2(NEEDLE_SLOTS);
  localparam int LEN_W         = 6;
  localparam int FILL_W        = $clog2(MAX_NEEDLE + 1);

  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int MATCH_START_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LOW    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_SECOND = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_THIRD  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_HIGH   = 3'd4;

  typedef logic [7:0]               byte_t;
  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [FILL_W-1:0]        fill_t;
  typedef logic [LEN_W-1:0]         len_t;

endpackage

@@ hw/rtl/ssrch_in_if.sv @@
// ----------------------------------------------------------------------------
// Haystack input channel
// Valid/ready channel carrying one haystack byte and its end marker per beat.
// ----------------------------------------------------------------------------
interface ssrch_in_if;
  logic                valid;
  logic                ready;
  ssrch_pkg::byte_t    hay_byte;
  logic                last_byte;

  modport source (output valid, output hay_byte, output last_byte, input ready);
  modport sink   (input valid, input hay_byte, input last_byte, output ready);
endinterface

@@ hw/rtl/ssrch_out_if.sv @@
// ----------------------------------------------------------------------------
// Search result channel
// Valid/ready channel carrying one search result per beat.
// ----------------------------------------------------------------------------
interface ssrch_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   match_found;
  logic [ssrch_pkg::MATCH_START_W-1:0]    match_start;
  logic                                   no_match;
  logic                                   haystack_done;

  modport source (output valid, output match_found, output match_start,
                  output no_match, output haystack_done, input ready);
  modport sink   (input valid, input match_found, input match_start,
                  input no_match, input haystack_done, output ready);
endinterface

@@ hw/rtl/streaming_substring_search_top.sv @@
// ----------------------------------------------------------------------------
// Streaming substring search
// Finds the first occurrence of a configured needle in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one haystack byte per beat; last_byte marks the end of a
//   haystack. out_ch returns exactly one result beat per input beat, in order.
//   The first match in a haystack raises match_found with the index of the
//   match start; a haystack that ends without a match raises no_match on its
//   last beat. haystack_done echoes last_byte, after which the search state
//   clears for the next haystack. An empty needle matches at index 0.
//   The needle and its length are written through the cfg_ port; the user must
//   write them only while no beat is in flight, as the block does not enforce it.
// Timing:
//   A byte is captured in an input register, compared against the needle in
//   combinational logic (32 parallel byte compares on the shifted window) and
//   lands in the result register; throughput is 1 beat per cycle while the
//   receiver is ready. When the receiver stalls, the result register holds and
//   one more byte is kept in the input register before in_ch.ready drops.
//   A synchronous reset clears the needle, the window and the position.
// ----------------------------------------------------------------------------
module streaming_substring_search_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  ssrch_in_if.sink                             in_ch,
  ssrch_out_if.source                          out_ch,
  input  logic                                 cfg_we,
  input  logic [ssrch_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ssrch_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int MAXN = ssrch_pkg::MAX_NEEDLE;

  // Configuration
  ssrch_pkg::len_t                   needle_len_r;
  logic [ssrch_pkg::CFG_DATA_W-1:0]  needle_words_r [ssrch_pkg::NEEDLE_WORDS];
  ssrch_pkg::byte_t                  needle_byte    [ssrch_pkg::NEEDLE_SLOTS];

  // Input register
  logic                              s1_valid_r;
  ssrch_pkg::byte_t                  s1_byte_r;
  logic                              s1_last_r;

  // Search state
  ssrch_pkg::byte_t                  win_r   [MAXN];
  ssrch_pkg::byte_t                  win_nxt [MAXN];
  ssrch_pkg::pos_t                   seen_r, seen_nxt;
  ssrch_pkg::fill_t                  fill_r, fill_inc;
  logic                              matched_r;

  // Result register
  logic                              out_valid_r;
  logic                              found_r;
  logic [ssrch_pkg::MATCH_START_W-1:0] start_r;
  logic                              no_match_r;
  logic                              done_r;

  // Compare path
  ssrch_pkg::len_t                   len_eff;
  logic [ssrch_pkg::SLOT_W-1:0]      slot_idx [MAXN];
  logic [MAXN-1:0]                   byte_ok;
  logic                              found;
  ssrch_pkg::pos_t                   start_pos;
  logic                              adv;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_len_r <= '0;
      for (int w = 0; w < ssrch_pkg::NEEDLE_WORDS; w++) begin
        needle_words_r[w] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssrch_pkg::REG_NEEDLE_LENGTH: needle_len_r      <= cfg_wdata[ssrch_pkg::LEN_W-1:0];
        ssrch_pkg::REG_NEEDLE_LOW:    needle_words_r[0] <= cfg_wdata;
        ssrch_pkg::REG_NEEDLE_SECOND: needle_words_r[1] <= cfg_wdata;
        ssrch_pkg::REG_NEEDLE_THIRD:  needle_words_r[2] <= cfg_wdata;
        ssrch_pkg::REG_NEEDLE_HIGH:   needle_words_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < ssrch_pkg::NEEDLE_SLOTS; k++) begin
      needle_byte[k] = needle_words_r[k / 8][(k % 8) * 8 +: 8];
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.hay_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Window compare
  // ---------------------------------------------------------------------------
  always_comb begin
    len_eff = (needle_len_r > ssrch_pkg::LEN_W'(MAXN)) ? ssrch_pkg::LEN_W'(MAXN)
                                                        : needle_len_r;
    fill_inc = (fill_r < ssrch_pkg::FILL_W'(MAXN)) ? fill_r + 1'b1 : fill_r;

    win_nxt[0] = s1_byte_r;
    for (int k = 1; k < MAXN; k++) begin
      win_nxt[k] = win_r[k-1];
    end

    // Window entry k (newest first) lines up with needle byte len-1-k.
    for (int k = 0; k < MAXN; k++) begin
      slot_idx[k] = ssrch_pkg::SLOT_W'(len_eff - ssrch_pkg::LEN_W'(1)
                                       - ssrch_pkg::LEN_W'(k));
      byte_ok[k]  = (ssrch_pkg::LEN_W'(k) >= len_eff) ||
                    (win_nxt[k] == needle_byte[slot_idx[k]]);
    end

    found = !matched_r &&
            ((len_eff == '0) ||
             ((ssrch_pkg::LEN_W'(fill_inc) >= len_eff) && (&byte_ok)));

    start_pos = (len_eff == '0) ? '0
              : seen_r - ssrch_pkg::POSITION_BITS'(len_eff - ssrch_pkg::LEN_W'(1));

    seen_nxt = (&seen_r) ? seen_r : seen_r + 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Search state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAXN; k++) begin
        win_r[k] <= '0;
      end
      seen_r    <= '0;
      fill_r    <= '0;
      matched_r <= 1'b0;
    end else if (adv) begin
      if (s1_last_r) begin
        for (int k = 0; k < MAXN; k++) begin
          win_r[k] <= '0;
        end
        seen_r    <= '0;
        fill_r    <= '0;
        matched_r <= 1'b0;
      end else begin
        win_r     <= win_nxt;
        seen_r    <= seen_nxt;
        fill_r    <= fill_inc;
        matched_r <= matched_r || found;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      found_r    <= found;
      start_r    <= found ? ssrch_pkg::MATCH_START_W'(start_pos) : '0;
      no_match_r <= s1_last_r && !(matched_r || found);
      done_r     <= s1_last_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.match_found   = found_r;
  assign out_ch.match_start   = start_r;
  assign out_ch.no_match      = no_match_r;
  assign out_ch.haystack_done = done_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_found_excludes_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(found_r && no_match_r))
    else $error("match_found and no_match both set");

  a_nomatch_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && no_match_r) |-> done_r)
    else $error("no_match outside the last beat of a haystack");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_last_r) |=> (seen_r == '0 && fill_r == '0 && !matched_r))
    else $error("search state not cleared after the last beat");

  a_match_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && found && !s1_last_r) |=> matched_r)
    else $error("match flag not kept after a reported match");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= ssrch_pkg::FILL_W'(MAXN))
    else $error("window fill count beyond the window size");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> s1_valid_r)
    else $error("input register dropped a byte while stalled");

endmodule
